// File: hdl/lav_pkg.sv
// Shared types and constants of the look-at view matrix block.
package lav_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = 33;
	localparam int ACC_W     = 64;
	localparam int OPND_W    = 33;
	localparam int ROWS      = 4;
	localparam int IN_DEPTH  = 2;
	localparam int OUT_DEPTH = 4;

	localparam logic [1:0] VEC_DIR  = 2'd0;
	localparam logic [1:0] VEC_RGT  = 2'd1;
	localparam logic [1:0] VEC_UPV  = 2'd2;
	localparam logic [1:0] LAST_ROW = 2'd3;

	// One camera update as held in the queue between front and back.
	typedef struct packed {
		logic [2:0][COORD_W-1:0] eye;
		logic [2:0][COORD_W-1:0] up;
		logic [2:0][DIFF_W-1:0]  diff;
		logic                    dir_zero;
	} cam_item_t;

	// One matrix row as handed out.
	typedef struct packed {
		logic [1:0]         row_index;
		logic [COORD_W-1:0] col_one;
		logic [COORD_W-1:0] col_two;
		logic [COORD_W-1:0] col_three;
		logic               last_row;
		logic               degenerate;
	} row_item_t;

	// Handshake between the front queue and the back sequencer.
	typedef struct packed {
		logic valid;
		logic take;
	} link_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ABS, ST_SHIFT, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT, ST_DIV_INIT, ST_DIV,
		ST_NEXT, ST_CR_MUL, ST_CR_ACC, ST_DOT_MUL, ST_DOT_ACC, ST_TRANS, ST_WAIT, ST_EMIT
	} back_state_t;

	function automatic logic [1:0] next3(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

endpackage

// File: hdl/lav_fifo.sv
// Small first-in first-out queue built from registers.
module lav_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [W-1:0]               wr_data,
	input  logic                       rd_en,
	output logic [W-1:0]               rd_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign do_wr   = wr_en && (count_q != CW'(DEPTH));
	assign do_rd   = rd_en && (count_q != '0);
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(do_wr) - CW'(do_rd);
		end
	end

endmodule

// File: hdl/lav_front.sv
// Front end: takes camera updates, forms the view direction and queues them.
module lav_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic [2:0][lav_pkg::COORD_W-1:0]       eye,
	input  logic [2:0][lav_pkg::COORD_W-1:0]       target,
	input  logic [2:0][lav_pkg::COORD_W-1:0]       up,
	output lav_pkg::cam_item_t                     head,
	input  lav_pkg::link_t                         link_in,
	output lav_pkg::link_t                         link_out
);
	import lav_pkg::*;

	cam_item_t                         item;
	logic                              q_empty;
	logic [$clog2(IN_DEPTH+1)-1:0]     q_count;

	// The direction is classified here so that the back can skip its
	// normalisation when the eye sits on the target.
	always_comb begin
		item.eye = eye;
		item.up  = up;
		for (int i = 0; i < 3; i++) begin
			item.diff[i] = {target[i][COORD_W-1], target[i]} - {eye[i][COORD_W-1], eye[i]};
		end
		item.dir_zero = (item.diff == '0);
	end

	lav_fifo #(
		.W    ($bits(cam_item_t)),
		.DEPTH(IN_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(item),
		.rd_en  (link_in.take),
		.rd_data(head),
		.empty  (q_empty),
		.full   (full),
		.count  (q_count)
	);

	assign link_out.valid = !q_empty && (q_count != '0);
	assign link_out.take  = 1'b0;

endmodule

// File: hdl/lav_back.sv
// Back end: normalisation, cross and dot products, and row output sequencing.
module lav_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  lav_pkg::cam_item_t                        head,
	input  lav_pkg::link_t                            link_in,
	output lav_pkg::link_t                            link_out,
	input  logic [$clog2(lav_pkg::OUT_DEPTH+1)-1:0]   out_count,
	output logic                                      out_wr,
	output lav_pkg::row_item_t                        out_row
);
	import lav_pkg::*;

	localparam int UW = FRAC_BITS + 2;
	localparam int KW = $clog2(UW);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	back_state_t state_q, state_d;

	logic [COORD_W-1:0]       eye_q [3];
	logic [COORD_W-1:0]       up_q  [3];
	logic signed [ACC_W-1:0]  v_q   [3];
	logic [ACC_W-1:0]         w_q   [3];
	logic                     neg_q [3];
	logic signed [UW-1:0]     dir_q [3];
	logic signed [UW-1:0]     rgt_q [3];
	logic signed [UW-1:0]     upv_q [3];
	logic [COORD_W-1:0]       trans_q [3];
	logic [ACC_W-1:0]         sum_q, sq_n_q, sq_r_q, bit_q, rem_q;
	logic [COORD_W-1:0]       len_q;
	logic [UW-1:0]            quo_q;
	logic signed [ACC_W-1:0]  prod_q, acc_q;
	logic [KW-1:0]            k_q;
	logic [1:0]               idx_q, vsel_q, dk_q, row_q;
	logic [2:0]               cnt_q;
	logic                     deg_q;

	logic signed [OPND_W-1:0]   mul_a, mul_b;
	logic signed [2*OPND_W-1:0] mul_p;
	logic [ACC_W-1:0]           w_or, sq_sub, sq_r_next, sum_next, dsub;
	logic                       sq_ge, div_ge, big;
	logic [UW-1:0]              quo_next;
	logic signed [UW-1:0]       unit_val;
	logic [1:0]                 cj, c1, c2, ca, cb;
	logic [ACC_W-1:0]           t_mag, t_rnd;
	logic                       t_neg;
	logic [COORD_W-1:0]         t_sat;

	function automatic logic signed [OPND_W-1:0] ext_u(input logic signed [UW-1:0] x);
		return {{(OPND_W-UW){x[UW-1]}}, x};
	endfunction

	function automatic logic [COORD_W-1:0] ext_c(input logic signed [UW-1:0] x);
		return {{(COORD_W-UW){x[UW-1]}}, x};
	endfunction

	assign w_or      = w_q[0] | w_q[1] | w_q[2];
	assign big       = (w_or[ACC_W-1:30] != '0);
	assign sum_next  = sum_q + prod_q;
	assign sq_sub    = sq_r_q + bit_q;
	assign sq_ge     = (sq_n_q >= sq_sub);
	assign sq_r_next = sq_ge ? ((sq_r_q >> 1) + bit_q) : (sq_r_q >> 1);
	assign dsub      = {{(ACC_W-COORD_W){1'b0}}, len_q} << k_q;
	assign div_ge    = (rem_q >= dsub);
	assign quo_next  = quo_q | (div_ge ? (UW'(1) << k_q) : '0);
	assign unit_val  = neg_q[idx_q] ? UW'(-quo_next) : UW'(quo_next);

	// Cross product term selection: even counts load the product, odd counts subtract.
	assign cj = cnt_q[2:1];
	assign c1 = next3(cj);
	assign c2 = next3(c1);
	assign ca = cnt_q[0] ? c2 : c1;
	assign cb = cnt_q[0] ? c1 : c2;

	// Translation rounding and saturation, halves away from zero.
	always_comb begin
		t_neg = !acc_q[ACC_W-1] && (acc_q != '0);
		t_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		t_rnd = (t_mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (t_neg) begin
			t_sat = (t_rnd > ACC_W'(64'h8000_0000)) ? 32'h8000_0000 : COORD_W'(-t_rnd);
		end else begin
			t_sat = (t_rnd > ACC_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : t_rnd[COORD_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (link_in.valid) state_d = head.dir_zero ? ST_NEXT : ST_ABS;
			ST_ABS:      state_d = ST_SHIFT;
			ST_SHIFT:    if (!big) state_d = ST_SQ_MUL;
			ST_SQ_MUL:   state_d = ST_SQ_ACC;
			ST_SQ_ACC: begin
				if (idx_q == 2'd2) state_d = (sum_next == '0) ? ST_NEXT : ST_SQRT;
				else state_d = ST_SQ_MUL;
			end
			ST_SQRT:     if (bit_q[0]) state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (k_q == '0) state_d = (idx_q == 2'd2) ? ST_NEXT : ST_DIV_INIT;
			end
			ST_NEXT:     state_d = (vsel_q == VEC_UPV) ? ST_DOT_MUL : ST_CR_MUL;
			ST_CR_MUL:   state_d = ST_CR_ACC;
			ST_CR_ACC:   state_d = (cnt_q == 3'd5) ? ST_ABS : ST_CR_MUL;
			ST_DOT_MUL:  state_d = ST_DOT_ACC;
			ST_DOT_ACC:  state_d = (idx_q == 2'd2) ? ST_TRANS : ST_DOT_MUL;
			ST_TRANS:    state_d = (dk_q == 2'd2) ? ST_WAIT : ST_DOT_MUL;
			ST_WAIT:     if (out_count <= OCW'(OUT_DEPTH - ROWS)) state_d = ST_EMIT;
			ST_EMIT:     if (row_q == LAST_ROW) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs and multiplier operands.
	always_comb begin
		link_out.valid = 1'b0;
		link_out.take  = (state_q == ST_IDLE) && link_in.valid;
		out_wr         = (state_q == ST_EMIT);
		out_row.row_index  = row_q;
		out_row.last_row   = (row_q == LAST_ROW);
		out_row.degenerate = deg_q;
		if (row_q == LAST_ROW) begin
			out_row.col_one   = trans_q[0];
			out_row.col_two   = trans_q[1];
			out_row.col_three = trans_q[2];
		end else begin
			out_row.col_one   = ext_c(rgt_q[row_q]);
			out_row.col_two   = ext_c(upv_q[row_q]);
			out_row.col_three = ext_c(dir_q[row_q]);
		end
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ_MUL: begin
				mul_a = {3'b000, w_q[idx_q][29:0]};
				mul_b = {3'b000, w_q[idx_q][29:0]};
			end
			ST_CR_MUL: begin
				if (vsel_q == VEC_DIR) begin
					mul_a = {up_q[ca][COORD_W-1], up_q[ca]};
					mul_b = ext_u(dir_q[cb]);
				end else begin
					mul_a = ext_u(dir_q[ca]);
					mul_b = ext_u(rgt_q[cb]);
				end
			end
			ST_DOT_MUL: begin
				mul_a = {eye_q[idx_q][COORD_W-1], eye_q[idx_q]};
				unique case (dk_q)
					2'd0:    mul_b = ext_u(rgt_q[idx_q]);
					2'd1:    mul_b = ext_u(upv_q[idx_q]);
					default: mul_b = ext_u(dir_q[idx_q]);
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			vsel_q  <= VEC_DIR;
			dk_q    <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					vsel_q <= VEC_DIR;
					idx_q  <= '0;
					row_q  <= '0;
				end
				ST_ABS:      idx_q <= '0;
				ST_SQ_ACC:   idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				ST_DIV_INIT: k_q <= KW'(UW - 1);
				ST_DIV: begin
					k_q <= k_q - KW'(1);
					if (k_q == '0) idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				ST_NEXT: begin
					cnt_q <= '0;
					idx_q <= '0;
					dk_q  <= '0;
				end
				ST_CR_ACC: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) vsel_q <= vsel_q + 2'd1;
				end
				ST_DOT_ACC:  idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				ST_TRANS:    dk_q <= dk_q + 2'd1;
				ST_EMIT:     row_q <= row_q + 2'd1;
				default:     idx_q <= idx_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p[ACC_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (link_in.valid) begin
					deg_q <= head.dir_zero;
					for (int i = 0; i < 3; i++) begin
						eye_q[i] <= head.eye[i];
						up_q[i]  <= head.up[i];
						v_q[i]   <= {{(ACC_W-DIFF_W){head.diff[i][DIFF_W-1]}}, head.diff[i]};
						dir_q[i] <= '0;
					end
				end
			end
			ST_ABS: begin
				sum_q <= '0;
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= v_q[i][ACC_W-1];
					w_q[i]   <= v_q[i][ACC_W-1] ? ACC_W'(-v_q[i]) : ACC_W'(v_q[i]);
				end
			end
			ST_SHIFT: begin
				if (big) begin
					for (int i = 0; i < 3; i++) w_q[i] <= w_q[i] >> 1;
				end
			end
			ST_SQ_ACC: begin
				sum_q <= sum_next;
				if (idx_q == 2'd2) begin
					sq_n_q <= sum_next;
					sq_r_q <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
					if (sum_next == '0) begin
						deg_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							if (vsel_q == VEC_DIR) dir_q[i] <= '0;
							else if (vsel_q == VEC_RGT) rgt_q[i] <= '0;
							else upv_q[i] <= '0;
						end
					end
				end
			end
			ST_SQRT: begin
				if (sq_ge) sq_n_q <= sq_n_q - sq_sub;
				sq_r_q <= sq_r_next;
				bit_q  <= bit_q >> 2;
				if (bit_q[0]) len_q <= sq_r_next[COORD_W-1:0];
			end
			ST_DIV_INIT: begin
				rem_q <= (w_q[idx_q] << FRAC_BITS) + ACC_W'(len_q >> 1);
				quo_q <= '0;
			end
			ST_DIV: begin
				if (div_ge) rem_q <= rem_q - dsub;
				quo_q <= quo_next;
				if (k_q == '0) begin
					if (vsel_q == VEC_DIR) dir_q[idx_q] <= unit_val;
					else if (vsel_q == VEC_RGT) rgt_q[idx_q] <= unit_val;
					else upv_q[idx_q] <= unit_val;
				end
			end
			ST_NEXT:     acc_q <= '0;
			ST_CR_ACC: begin
				if (!cnt_q[0]) v_q[cj] <= prod_q;
				else v_q[cj] <= v_q[cj] - prod_q;
			end
			ST_DOT_ACC:  acc_q <= acc_q + prod_q;
			ST_TRANS: begin
				trans_q[dk_q] <= t_sat;
				acc_q <= '0;
			end
			default:     sum_q <= sum_q;
		endcase
	end

endmodule

// File: hdl/look_at_view_matrix.sv
// Top level of the left-handed look-at view matrix block.
//
// Both sides look like a queue. A camera update (eye, target and up hint as
// signed fixed-point triples) is taken when push is high and full is low; a
// two-entry queue behind the front end holds updates while the back end works.
// Each update gives four row items, rows 0 to 3 in order. The oldest row
// stands on the result ports while empty is low and leaves when pop is high.
// The back end uses one shared 33 by 33 bit multiplier, a square root that
// settles one result bit a cycle and a divider that settles one quotient bit
// a cycle. Each of the three normalisations first halves the vector until its
// magnitude fits in 30 bits. The back end takes the next update from the queue
// only once it has written all four rows of the last one.
// Rows go into a four-entry output queue; the back end starts writing a new
// set only when all four fit, so a stalled receiver simply holds the back end
// once the queues are full. Reset empties both queues and returns the
// sequencer to idle; no item is kept across reset.
module look_at_view_matrix #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] eye_x,
	input  logic [31:0] eye_y,
	input  logic [31:0] eye_z,
	input  logic [31:0] target_x,
	input  logic [31:0] target_y,
	input  logic [31:0] target_z,
	input  logic [31:0] up_x,
	input  logic [31:0] up_y,
	input  logic [31:0] up_z,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  row_index,
	output logic [31:0] col_one,
	output logic [31:0] col_two,
	output logic [31:0] col_three,
	output logic        last_row,
	output logic        degenerate
);
	import lav_pkg::*;

	cam_item_t                          head;
	link_t                              front_link, back_link;
	row_item_t                          wr_row, rd_row;
	logic                               out_wr, out_full;
	logic [$clog2(OUT_DEPTH+1)-1:0]     out_count;

	lav_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.eye     ({eye_z, eye_y, eye_x}),
		.target  ({target_z, target_y, target_x}),
		.up      ({up_z, up_y, up_x}),
		.head    (head),
		.link_in (back_link),
		.link_out(front_link)
	);

	lav_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.link_in  (front_link),
		.link_out (back_link),
		.out_count(out_count),
		.out_wr   (out_wr),
		.out_row  (wr_row)
	);

	// The back end only writes when room for a whole set was seen, so the
	// full flag of the output queue never throttles a write.
	lav_fifo #(
		.W    ($bits(row_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_wr && !out_full),
		.wr_data(wr_row),
		.rd_en  (pop),
		.rd_data(rd_row),
		.empty  (empty),
		.full   (out_full),
		.count  (out_count)
	);

	assign row_index  = rd_row.row_index;
	assign col_one    = rd_row.col_one;
	assign col_two    = rd_row.col_two;
	assign col_three  = rd_row.col_three;
	assign last_row   = rd_row.last_row;
	assign degenerate = rd_row.degenerate;

	// After the last row of a set, the next row shown starts a new set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && last_row) |=> (empty || row_index == 2'd0))
		else $error("row after last row is not row 0");

	// Rows of one set follow each other and share the degenerate flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_row) |=>
		(!empty && row_index == $past(row_index) + 2'd1 && degenerate == $past(degenerate)))
		else $error("rows of one set broken");

	// The last row flag marks row 3 and nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_row == (row_index == LAST_ROW)))
		else $error("last_row does not match row_index");

	// Reset leaves no row to deliver.
	assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty in reset");

endmodule
